// ===== design/tmec_pkg.sv =====
// Shared types and constants for the triangle enclosing circle block.
`timescale 1ns / 1ps
package tmec_pkg;
   localparam int CoordWidth  = 16;
   localparam int RadiusWidth = CoordWidth + 1;

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_a_x;
      logic signed [CoordWidth-1:0] point_a_y;
      logic signed [CoordWidth-1:0] point_b_x;
      logic signed [CoordWidth-1:0] point_b_y;
      logic signed [CoordWidth-1:0] point_c_x;
      logic signed [CoordWidth-1:0] point_c_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] center_x;
      logic signed [CoordWidth-1:0] center_y;
      logic [RadiusWidth-1:0]       radius;
      logic                         via_circumcircle;
   } rsp_payload_type;
endpackage

// ===== design/tmec_req_if.sv =====
// Valid/ready channel interfaces for the triangle and circle transfers.
`timescale 1ns / 1ps
interface tmec_req_if;
   import tmec_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tmec_rsp_if;
   import tmec_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/triangle_min_enclosing_circle.sv =====
// Top level: smallest enclosing circle of a triangle, fully pipelined.
// Pipeline: four arithmetic stages, the divider (one stage per numerator bit), one select
//   stage and the root unit (one bit per stage).
// Throughput: one triangle per cycle; the whole pipe halts while the output is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps
module triangle_min_enclosing_circle (
   input logic    clock,
   input logic    reset,
   tmec_req_if.sink   req,
   tmec_rsp_if.source rsp
);
   import tmec_pkg::*;
   localparam int W  = CoordWidth;
   localparam int EW = W + 1;        // edge component
   localparam int MW = 2 * EW + 1;   // squared edge length
   localparam int NW = 2 * W + 1;    // |p|^2
   localparam int LW = NW + EW + 2;  // numerator
   localparam int DW = W + EW + 3;   // denominator
   localparam int SW = 2 * (W + 2) + 2; // squared radius, even
   localparam int DLAT = LW;
   localparam int SLAT = SW / 2;
   localparam int DEPTH = 4 + DLAT + 1 + SLAT;

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   assign advance = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
   end

   // stage 1: points, edges
   logic signed [W-1:0]  px_ff[3], py_ff[3];
   logic signed [EW-1:0] ex_ff[3], ey_ff[3];
   logic signed [W-1:0]  ipx[3], ipy[3];
   assign ipx[0] = W'(req.payload.point_a_x); assign ipy[0] = W'(req.payload.point_a_y);
   assign ipx[1] = W'(req.payload.point_b_x); assign ipy[1] = W'(req.payload.point_b_y);
   assign ipx[2] = W'(req.payload.point_c_x); assign ipy[2] = W'(req.payload.point_c_y);

   // stage 2: squares
   logic signed [W-1:0]  p2x_ff[3], p2y_ff[3];
   logic signed [EW-1:0] e2x_ff[3], e2y_ff[3];
   logic [MW-1:0] m_ff[3];
   logic [NW-1:0] n_ff[3];
   logic signed [DW-1:0] dp_ff[3];
   // stage 3: products
   logic signed [W-1:0]  p3x_ff[3], p3y_ff[3];
   logic [MW-1:0] m3_ff[3];
   logic signed [LW-1:0] lxp_ff[3], lyp_ff[3];
   logic signed [DW-1:0] den3_ff;
   // stage 4: sums, case decision
   logic signed [LW-1:0] lx_ff, ly_ff;
   logic signed [DW-1:0] den_ff;
   logic acute_ff;
   logic signed [W-1:0] mcx_ff, mcy_ff, ax_ff, ay_ff;
   logic [MW-1:0] mk_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            px_ff[i] <= ipx[i]; py_ff[i] <= ipy[i];
            ex_ff[i] <= EW'(ipx[i]) - EW'(ipx[(i+1)%3]);
            ey_ff[i] <= EW'(ipy[i]) - EW'(ipy[(i+1)%3]);
         end
         for (int i = 0; i < 3; i++) begin
            p2x_ff[i] <= px_ff[i]; p2y_ff[i] <= py_ff[i];
            e2x_ff[i] <= ex_ff[i]; e2y_ff[i] <= ey_ff[i];
            m_ff[i] <= MW'(ex_ff[i] * ex_ff[i]) + MW'(ey_ff[i] * ey_ff[i]);
            n_ff[i] <= NW'(px_ff[i] * px_ff[i]) + NW'(py_ff[i] * py_ff[i]);
         end
         dp_ff[0] <= DW'(ey_ff[1] * px_ff[0]);
         dp_ff[1] <= DW'(ey_ff[2] * px_ff[1]);
         dp_ff[2] <= DW'(ey_ff[0] * px_ff[2]);
         for (int i = 0; i < 3; i++) begin
            p3x_ff[i] <= p2x_ff[i]; p3y_ff[i] <= p2y_ff[i]; m3_ff[i] <= m_ff[i];
            lxp_ff[i] <= LW'(e2x_ff[(i+1)%3] * $signed({1'b0, n_ff[i]}));
            lyp_ff[i] <= LW'(e2y_ff[(i+1)%3] * $signed({1'b0, n_ff[i]}));
         end
         den3_ff <= DW'((dp_ff[0] + dp_ff[1] + dp_ff[2]) <<< 1);
         lx_ff <= lxp_ff[0] + lxp_ff[1] + lxp_ff[2];
         ly_ff <= lyp_ff[0] + lyp_ff[1] + lyp_ff[2];
         den_ff <= den3_ff;
         acute_ff <= ({1'b0, m3_ff[0]} + {1'b0, m3_ff[1]} > {1'b0, m3_ff[2]}) &&
                     ({1'b0, m3_ff[1]} + {1'b0, m3_ff[2]} > {1'b0, m3_ff[0]}) &&
                     ({1'b0, m3_ff[2]} + {1'b0, m3_ff[0]} > {1'b0, m3_ff[1]});
         ax_ff <= p3x_ff[0]; ay_ff <= p3y_ff[0];
         priority if (m3_ff[2] > m3_ff[1] && m3_ff[2] > m3_ff[0]) begin
            mk_ff <= m3_ff[2];
            mcx_ff <= W'(((W+1)'(p3x_ff[2]) + (W+1)'(p3x_ff[0])) >>> 1);
            mcy_ff <= W'(((W+1)'(p3y_ff[2]) + (W+1)'(p3y_ff[0])) >>> 1);
         end else if (m3_ff[1] > m3_ff[0]) begin
            mk_ff <= m3_ff[1];
            mcx_ff <= W'(((W+1)'(p3x_ff[1]) + (W+1)'(p3x_ff[2])) >>> 1);
            mcy_ff <= W'(((W+1)'(p3y_ff[1]) + (W+1)'(p3y_ff[2])) >>> 1);
         end else begin
            mk_ff <= m3_ff[0];
            mcx_ff <= W'(((W+1)'(p3x_ff[0]) + (W+1)'(p3x_ff[1])) >>> 1);
            mcy_ff <= W'(((W+1)'(p3y_ff[0]) + (W+1)'(p3y_ff[1])) >>> 1);
         end
      end
   end

   // side data delayed alongside the divider
   typedef struct packed {
      logic acute;
      logic signed [W-1:0] mcx, mcy, ax, ay;
      logic [MW-1:0] mk;
   } side_type;
   side_type side_ff[DLAT+1];
   assign side_ff[0] = '{acute: acute_ff, mcx: mcx_ff, mcy: mcy_ff, ax: ax_ff,
                         ay: ay_ff, mk: mk_ff};
   for (genvar s = 0; s < DLAT; s++) begin : g_side
      always_ff @(posedge clock) if (advance) side_ff[s+1] <= side_ff[s];
   end

   logic signed [LW-1:0] qx, qy;
   tmec_pipe_div #(.NW(LW), .DW(DW)) u_div_x (
      .clock(clock), .advance(advance), .num(ly_ff), .den(den_ff), .quo(qx));
   tmec_pipe_div #(.NW(LW), .DW(DW)) u_div_y (
      .clock(clock), .advance(advance), .num(LW'(-lx_ff)), .den(den_ff), .quo(qy));

   function automatic logic signed [W-1:0] sat(input logic signed [LW-1:0] v);
      logic signed [LW-1:0] hi, lo;
      hi = LW'({1'b0, {(W-1){1'b1}}});
      lo = -hi - LW'(1);
      if (v > hi) return W'(hi);
      else if (v < lo) return W'(lo);
      else return W'(v);
   endfunction

   // select stage: choose center and root operand
   logic signed [W-1:0] cx_ff, cy_ff;
   logic [SW-1:0] sq_ff;
   logic acute_s_ff;
   side_type sd;
   logic signed [W-1:0] ccx, ccy;
   logic signed [W+1:0] dx, dy;
   assign sd  = side_ff[DLAT];
   assign ccx = sat(qx);
   assign ccy = sat(qy);
   assign dx  = (W+2)'(sd.ax) - (W+2)'(ccx);
   assign dy  = (W+2)'(sd.ay) - (W+2)'(ccy);

   always_ff @(posedge clock) begin
      if (advance) begin
         acute_s_ff <= sd.acute;
         if (sd.acute) begin
            cx_ff <= ccx; cy_ff <= ccy;
            sq_ff <= SW'(dx * dx) + SW'(dy * dy);
         end else begin
            cx_ff <= sd.mcx; cy_ff <= sd.mcy;
            sq_ff <= SW'(sd.mk);
         end
      end
   end

   typedef struct packed {
      logic acute;
      logic signed [W-1:0] cx, cy;
   } tail_type;
   tail_type tail_ff[SLAT+1];
   assign tail_ff[0] = '{acute: acute_s_ff, cx: cx_ff, cy: cy_ff};
   for (genvar s = 0; s < SLAT; s++) begin : g_tail
      always_ff @(posedge clock) if (advance) tail_ff[s+1] <= tail_ff[s];
   end

   logic [SW/2-1:0] root;
   tmec_pipe_sqrt #(.VW(SW)) u_sqrt (
      .clock(clock), .advance(advance), .val(sq_ff), .root(root));

   logic [SW/2-1:0] rad;
   assign rad = tail_ff[SLAT].acute ? root : (root >> 1);

   assign rsp.valid                    = vld_ff[DEPTH-1];
   assign rsp.payload.center_x         = CoordWidth'(tail_ff[SLAT].cx);
   assign rsp.payload.center_y         = CoordWidth'(tail_ff[SLAT].cy);
   assign rsp.payload.radius           = RadiusWidth'(rad);
   assign rsp.payload.via_circumcircle = tail_ff[SLAT].acute;
endmodule

// ===== design/tmec_pipe_div.sv =====
// Pipelined restoring signed divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tmec_pipe_div #(
   parameter int NW = 48,
   parameter int DW = 40
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic signed [NW-1:0] quo
);
   logic [NW-1:0] rem_ff [NW+1];
   logic [NW-1:0] q_ff   [NW+1];
   logic [DW-1:0] d_ff   [NW+1];
   logic          neg_ff [NW+1];
   logic          zero_ff[NW+1];

   always_comb begin
      rem_ff[0]  = num[NW-1] ? NW'(-num) : num;
      q_ff[0]    = '0;
      d_ff[0]    = den[DW-1] ? DW'(-den) : den;
      neg_ff[0]  = num[NW-1] ^ den[DW-1];
      zero_ff[0] = (den == '0);
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [2*NW-1:0] trial;
      logic            fits;
      assign trial = {{NW{1'b0}}, d_ff[s]} << (NW - 1 - s);
      assign fits  = {{NW{1'b0}}, rem_ff[s]} >= trial;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1]  <= fits ? NW'({{NW{1'b0}}, rem_ff[s]} - trial) : rem_ff[s];
            q_ff[s+1]    <= {q_ff[s][NW-2:0], fits};
            d_ff[s+1]    <= d_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
         end
      end
   end

   assign quo = zero_ff[NW] ? '0 : (neg_ff[NW] ? NW'(-q_ff[NW]) : q_ff[NW]);
endmodule

// ===== design/tmec_pipe_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
module tmec_pipe_sqrt #(
   parameter int VW = 40
) (
   input  logic            clock,
   input  logic            advance,
   input  logic [VW-1:0]   val,
   output logic [VW/2-1:0] root
);
   localparam int RW = VW / 2;
   logic [VW-1:0] rem_ff[RW+1];
   logic [RW-1:0] res_ff[RW+1];

   assign rem_ff[0] = val;
   assign res_ff[0] = '0;

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [VW+1:0] trial;
      logic          fits;
      assign trial = ({2'b0, res_ff[s], {RW{1'b0}}} >> s) |
                     ((VW+2)'(1) << (2 * (RW - 1 - s)));
      assign fits  = {2'b0, rem_ff[s]} >= trial;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= fits ? VW'({2'b0, rem_ff[s]} - trial) : rem_ff[s];
            res_ff[s+1] <= res_ff[s] | (fits ? RW'(1) << (RW - 1 - s) : '0);
         end
      end
   end

   assign root = res_ff[RW];
endmodule

// ===== tb/tmec_circle_checker.sv =====
// Checker: predicts the enclosing circle of each accepted triangle and compares results.
`timescale 1ns / 1ps
module tmec_circle_checker (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  tmec_pkg::req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  tmec_pkg::rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              pending_count
);
   import tmec_pkg::*;

   rsp_payload_type circle_queue[$];
   int              mismatch_count;

   function automatic longint isqrt_floor(longint v);
      longint res;
      longint bitv;
      res  = 0;
      bitv = 64'sd1 << 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (CoordWidth - 1)) - 1;
      lo = -(64'sd1 <<< (CoordWidth - 1));
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint quot_trunc(longint n, longint d);
      if (d == 0) return 0;
      return n / d;
   endfunction

   function automatic rsp_payload_type enclosing_circle(req_payload_type t);
      longint px[3], py[3], ex[3], ey[3], m[3];
      longint n0, n1, n2, lx, ly, den, cx, cy, rad;
      int k, j;
      rsp_payload_type r;
      px[0] = t.point_a_x; py[0] = t.point_a_y;
      px[1] = t.point_b_x; py[1] = t.point_b_y;
      px[2] = t.point_c_x; py[2] = t.point_c_y;
      for (int i = 0; i < 3; i++) begin
         ex[i] = px[i] - px[(i + 1) % 3];
         ey[i] = py[i] - py[(i + 1) % 3];
         m[i]  = ex[i] * ex[i] + ey[i] * ey[i];
      end
      if (m[0] + m[1] > m[2] && m[1] + m[2] > m[0] && m[2] + m[0] > m[1]) begin
         n0  = px[0] * px[0] + py[0] * py[0];
         n1  = px[1] * px[1] + py[1] * py[1];
         n2  = px[2] * px[2] + py[2] * py[2];
         lx  = ex[1] * n0 + ex[2] * n1 + ex[0] * n2;
         ly  = ey[1] * n0 + ey[2] * n1 + ey[0] * n2;
         den = 2 * (ey[1] * px[0] + ey[2] * px[1] + ey[0] * px[2]);
         cx  = clamp_coord(quot_trunc(ly, den));
         cy  = clamp_coord(quot_trunc(-lx, den));
         rad = isqrt_floor((px[0] - cx) * (px[0] - cx) + (py[0] - cy) * (py[0] - cy));
         r.via_circumcircle = 1'b1;
      end else begin
         k = 0;
         if (m[1] > m[k]) k = 1;
         if (m[2] > m[k]) k = 2;
         j   = (k + 1) % 3;
         cx  = (px[k] + px[j]) >>> 1;
         cy  = (py[k] + py[j]) >>> 1;
         rad = isqrt_floor(m[k]) >>> 1;
         r.via_circumcircle = 1'b0;
      end
      r.center_x = cx[CoordWidth-1:0];
      r.center_y = cy[CoordWidth-1:0];
      r.radius   = rad[RadiusWidth-1:0];
      return r;
   endfunction

   assign pending_count = circle_queue.size();

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         circle_queue.delete();
         fail_count     <= 0;
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready)
            circle_queue.push_back(enclosing_circle(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (circle_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected circle transfer: %p", rsp_payload);
            end else begin
               want = circle_queue.pop_front();
               if (want.center_x !== rsp_payload.center_x ||
                   want.center_y !== rsp_payload.center_y ||
                   want.radius !== rsp_payload.radius ||
                   want.via_circumcircle !== rsp_payload.via_circumcircle) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("circle mismatch: expected %p, got %p", want, rsp_payload);
               end
            end
         end
         fail_count <= mismatch_count;
      end
   end
endmodule

// ===== tb/triangle_min_enclosing_circle_tb.sv =====
// Testbench top: drives triangles, stalls the circle channel, gives the verdict.
`timescale 1ns / 1ps
module triangle_min_enclosing_circle_tb;
   import tmec_pkg::*;

   localparam int NumRandom   = 750;
   localparam int DrainCycles = 4 * CoordWidth + 12 + 40;
   localparam int IdleLimit   = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;
   bit   quiet_phase = 1'b0;
   int   rsp_gap     = 0;

   tmec_req_if req ();
   tmec_rsp_if rsp ();

   triangle_min_enclosing_circle dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   tmec_circle_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (quiet_phase) begin
         rsp.ready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_gap   <= $urandom_range(0, 15);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] pick_coord();
      unique case ($urandom_range(0, 5))
         0:       return 16'(16'h7fff - $urandom_range(0, 3));
         1:       return 16'(16'h8000 + $urandom_range(0, 3));
         2:       return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_triangle(input req_payload_type t);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_points(input int ax, ay, bx, by, cx, cy);
      req_payload_type t;
      t = '{ax[15:0], ay[15:0], bx[15:0], by[15:0], cx[15:0], cy[15:0]};
      send_triangle(t);
   endtask

   initial begin
      req_payload_type t;
      int base_x, base_y, span;
      req.valid   = 1'b0;
      req.payload = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // acute, right, obtuse, collinear, coincident, equal longest edges
      send_points(0, 0, 256, 0, 128, 200);
      send_points(0, 0, 256, 0, 0, 256);
      send_points(0, 0, 1000, 0, 100, 50);
      send_points(0, 0, 100, 100, 200, 200);
      send_points(5, 5, 5, 5, 5, 5);
      send_points(0, 0, 0, 0, 0, 0);
      send_points(-100, 0, 100, 0, 0, 100);
      send_points(0, 0, 100, 0, 50, 86);
      send_points(32767, 32767, -32768, -32768, 32767, -32768);
      send_points(-32768, -32768, -32768, -32768, -32768, -32768);
      send_points(32767, 32767, 32767, 32767, 32767, 32767);
      send_points(-32768, 0, 32767, 0, 0, 32767);
      send_points(-32768, -32768, 32767, -32768, 0, 32767);
      send_points(30000, 30000, 32767, 30000, 31000, 32767);
      send_points(-1, -1, 0, -1, -1, 0);
      send_points(0, 0, 3, 0, 1, 1);
      send_points(100, 0, 0, 0, 0, 100);
      send_points(0, 100, 100, 0, 0, 0);
      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom - 100) quiet_phase = 1'b1;
         if ($urandom_range(0, 2) == 0) begin
            t = '{pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_coord()};
         end else begin
            // clustered vertices give many acute triangles
            span   = 1 << $urandom_range(2, 14);
            base_x = $signed(pick_coord());
            base_y = $signed(pick_coord());
            t.point_a_x = 16'(base_x + $urandom_range(0, span) - span / 2);
            t.point_a_y = 16'(base_y + $urandom_range(0, span) - span / 2);
            t.point_b_x = 16'(base_x + $urandom_range(0, span) - span / 2);
            t.point_b_y = 16'(base_y + $urandom_range(0, span) - span / 2);
            t.point_c_x = 16'(base_x + $urandom_range(0, span) - span / 2);
            t.point_c_y = 16'(base_y + $urandom_range(0, span) - span / 2);
         end
         send_triangle(t);
      end
      req.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
